// File: hdl/oscillation_peak_analyzer_top_assert.svh
// Assertion macros shared by the analyzer modules.
// Each expects i_clk and i_rst_n in the scope of the module that uses it.
`ifndef OSCILLATION_PEAK_ANALYZER_TOP_ASSERT_SVH
`define OSCILLATION_PEAK_ANALYZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define OPA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/opa_pkg.sv
package opa_pkg;

    localparam int SampleW   = 24;
    localparam int MagW      = SampleW;
    localparam int P2pW      = SampleW + 1;
    localparam int CountW    = 15;
    localparam int IndexW    = 14;
    localparam int PeakCntW  = 5;
    localparam int GapSumW   = 15;
    localparam int GapCntW   = 5;
    localparam int ChangeW   = 29;
    localparam int TolW      = 16;
    localparam int TolCntW   = TolW + PeakCntW;
    localparam int RhsW      = TolCntW + SampleW;
    localparam int LhsShift  = 17;
    localparam int LhsW      = ChangeW + LhsShift;
    localparam int FracW     = 8;
    localparam int DivW      = GapSumW + FracW;
    localparam int PeriodW   = 22;
    localparam int OutDataW  = 64;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 16;

    localparam int MaxPeaks  = 20;
    localparam int RunLength = 16384;
    localparam int MinPeaks  = 3;
    localparam int MinGaps   = 2;

    localparam logic [TolW-1:0]   TolReset        = 16'd655;
    localparam logic [CountW-1:0] MinSamplesReset = 15'd100;
    localparam logic [IndexW-1:0] SkipReset       = 14'd50;
    localparam logic [IndexW-1:0] MinGapReset     = 14'd10;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TOLERANCE   = 2'd0,
        CFG_MIN_SAMPLES = 2'd1,
        CFG_SKIP        = 2'd2,
        CFG_MIN_GAP     = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic load;
        logic classify;
        logic update;
        logic calc;
        logic mult;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

// File: hdl/oscillation_peak_analyzer_top.sv
// Oscillation peak analyzer: takes plant output samples (signed 24 bit) and, for each one,
// returns the oscillation verdict, peak-to-peak value, mean period between maxima (Q14.8
// ticks) and the maxima/minima counts. Setting tuser on a sample clears the run first.
// A result is formed in order by classify, update, combine, one multiply stage and then
// the 23-step serial divider that forms the mean period. The next sample is taken only
// once the result of the last one is loaded, so s_axis_tready is high only while no
// sample is in work; a result waiting in the output register does not block the next
// sample, but that sample then holds before its result is loaded until the waiting one
// is taken. Configuration writes go through i_cfg_we/i_cfg_index/i_cfg_data; the user
// must make them only while idle, as the block itself does not enforce it.
module oscillation_peak_analyzer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [opa_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [opa_pkg::CfgDataW-1:0]      i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // [23:0] sample
    input  logic [0:0]                       s_axis_tuser,  // [0] first_of_run
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] oscillating, [25:1] peak_to_peak, [47:26] period_ticks,
    // [52:48] maxima_found, [57:53] minima_found, [63:58] zero
    output logic [opa_pkg::OutDataW-1:0]      m_axis_tdata
);

    opa_pkg::t_cmd    w_cmd;
    opa_pkg::t_status w_status;

    logic                                 w_osc;
    logic signed [opa_pkg::P2pW-1:0]      w_p2p;
    logic [opa_pkg::PeriodW-1:0]          w_period;
    logic [opa_pkg::PeakCntW-1:0]         w_maxf;
    logic [opa_pkg::PeakCntW-1:0]         w_minf;

    opa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    opa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (s_axis_tdata),
        .i_first     (s_axis_tuser[0]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_osc       (w_osc),
        .o_p2p       (w_p2p),
        .o_period    (w_period),
        .o_maxf      (w_maxf),
        .o_minf      (w_minf)
    );

    assign m_axis_tdata = {6'b0, w_minf, w_maxf, w_period, w_p2p, w_osc};

endmodule

// File: hdl/opa_div.sv
module opa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [opa_pkg::DivW-1:0]    i_dividend,
    input  logic [opa_pkg::GapCntW-1:0] i_divisor,
    output logic                       o_done,
    output logic [opa_pkg::DivW-1:0]    o_quotient
);

    localparam int CntW = $clog2(opa_pkg::DivW);

    logic                        r_busy;
    logic                        r_done;
    logic [CntW-1:0]             r_cnt;
    logic [opa_pkg::GapCntW-1:0] r_rem;
    logic [opa_pkg::DivW-1:0]    r_quo;

    logic [opa_pkg::GapCntW:0]   w_trial;
    logic [opa_pkg::GapCntW:0]   w_diff;
    logic                        w_ge;

    // One quotient bit a cycle, restoring.
    assign w_trial = {r_rem, r_quo[opa_pkg::DivW-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(opa_pkg::DivW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[opa_pkg::DivW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[opa_pkg::GapCntW-1:0] : w_trial[opa_pkg::GapCntW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hdl/opa_datapath.sv
`include "oscillation_peak_analyzer_top_assert.svh"

module opa_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [opa_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [opa_pkg::CfgDataW-1:0]        i_cfg_data,
    input  logic signed [opa_pkg::SampleW-1:0]  i_sample,
    input  logic                               i_first,
    input  opa_pkg::t_cmd                      i_cmd,
    output opa_pkg::t_status                   o_status,
    output logic                               o_osc,
    output logic signed [opa_pkg::P2pW-1:0]     o_p2p,
    output logic [opa_pkg::PeriodW-1:0]         o_period,
    output logic [opa_pkg::PeakCntW-1:0]        o_maxf,
    output logic [opa_pkg::PeakCntW-1:0]        o_minf
);

    localparam int SW = opa_pkg::SampleW;

    localparam logic signed [SW-1:0] SMax = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMin = {1'b1, {(SW-1){1'b0}}};

    // configuration
    logic [opa_pkg::TolW-1:0]   r_tol;
    logic [opa_pkg::CountW-1:0] r_min_samples;
    logic [opa_pkg::IndexW-1:0] r_skip;
    logic [opa_pkg::IndexW-1:0] r_min_gap;

    // run state
    logic signed [SW-1:0]          r_older;
    logic signed [SW-1:0]          r_middle;
    logic signed [SW-1:0]          r_cur;
    logic [opa_pkg::CountW-1:0]    r_sample_count;
    logic [opa_pkg::PeakCntW-1:0]  r_max_cnt;
    logic [opa_pkg::PeakCntW-1:0]  r_min_cnt;
    logic signed [SW-1:0]          r_highest;
    logic signed [SW-1:0]          r_lowest;
    logic [opa_pkg::IndexW-1:0]    r_last_idx;
    logic [opa_pkg::MagW-1:0]      r_last_mag;
    logic [opa_pkg::GapSumW-1:0]   r_gap_sum;
    logic [opa_pkg::GapCntW-1:0]   r_gap_cnt;
    logic [opa_pkg::ChangeW-1:0]   r_change_sum;

    // per-sample working registers
    logic                          r_is_max;
    logic                          r_is_min;
    logic [opa_pkg::IndexW-1:0]    r_idx;
    logic [opa_pkg::IndexW-1:0]    r_gap;
    logic [opa_pkg::MagW-1:0]      r_mag;
    logic signed [opa_pkg::P2pW-1:0] r_p2p;
    logic [opa_pkg::TolCntW-1:0]   r_tol_cnt;
    logic [opa_pkg::RhsW-1:0]      r_rhs;

    // result register
    logic                          r_out_osc;
    logic signed [opa_pkg::P2pW-1:0] r_out_p2p;
    logic [opa_pkg::PeriodW-1:0]   r_out_period;
    logic [opa_pkg::PeakCntW-1:0]  r_out_maxf;
    logic [opa_pkg::PeakCntW-1:0]  r_out_minf;

    logic [opa_pkg::IndexW-1:0]    w_idx;
    logic                          w_window;
    logic [opa_pkg::MagW-1:0]      w_mag;
    logic [opa_pkg::MagW-1:0]      w_mag_diff;
    logic                          w_clear;
    logic                          w_div_done;
    logic [opa_pkg::DivW-1:0]      w_quotient;
    logic [opa_pkg::LhsW-1:0]      w_lhs;
    logic                          w_enough;
    logic                          w_osc;
    logic [opa_pkg::PeriodW-1:0]   w_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol         <= opa_pkg::TolReset;
            r_min_samples <= opa_pkg::MinSamplesReset;
            r_skip        <= opa_pkg::SkipReset;
            r_min_gap     <= opa_pkg::MinGapReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                opa_pkg::CFG_TOLERANCE:   r_tol <= i_cfg_data;
                opa_pkg::CFG_MIN_SAMPLES: r_min_samples <= i_cfg_data[opa_pkg::CountW-1:0];
                opa_pkg::CFG_SKIP:        r_skip <= i_cfg_data[opa_pkg::IndexW-1:0];
                opa_pkg::CFG_MIN_GAP:     r_min_gap <= i_cfg_data[opa_pkg::IndexW-1:0];
                default: ;
            endcase
        end
    end

    // The sample before the newest one sits at index count-1.
    assign w_idx    = opa_pkg::IndexW'(r_sample_count - 1'b1);
    assign w_window = (r_sample_count < opa_pkg::CountW'(opa_pkg::RunLength))
                   && (r_sample_count >= opa_pkg::CountW'(2))
                   && (w_idx >= r_skip);
    assign w_mag    = r_middle[SW-1] ? (opa_pkg::MagW'(0) - opa_pkg::MagW'(r_middle))
                                     : opa_pkg::MagW'(r_middle);
    assign w_mag_diff = (r_mag > r_last_mag) ? (r_mag - r_last_mag) : (r_last_mag - r_mag);
    assign w_clear  = i_cmd.load && i_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_older        <= '0;
            r_middle       <= '0;
            r_sample_count <= '0;
            r_max_cnt      <= '0;
            r_min_cnt      <= '0;
            r_highest      <= SMin;
            r_lowest       <= SMax;
            r_last_idx     <= '0;
            r_last_mag     <= '0;
            r_gap_sum      <= '0;
            r_gap_cnt      <= '0;
            r_change_sum   <= '0;
        end else if (i_cmd.update) begin
            if (r_is_max) begin
                if (r_max_cnt != '0) begin
                    if (r_gap > r_min_gap) begin
                        r_gap_sum <= r_gap_sum + opa_pkg::GapSumW'(r_gap);
                        r_gap_cnt <= r_gap_cnt + 1'b1;
                    end
                    r_change_sum <= r_change_sum + opa_pkg::ChangeW'(w_mag_diff);
                end
                r_last_idx <= r_idx;
                r_last_mag <= r_mag;
                if (r_middle > r_highest) begin
                    r_highest <= r_middle;
                end
                r_max_cnt <= r_max_cnt + 1'b1;
            end
            if (r_is_min) begin
                if (r_middle < r_lowest) begin
                    r_lowest <= r_middle;
                end
                r_min_cnt <= r_min_cnt + 1'b1;
            end
            if (r_sample_count < opa_pkg::CountW'(opa_pkg::RunLength)) begin
                r_sample_count <= r_sample_count + 1'b1;
            end
            r_older  <= r_middle;
            r_middle <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur <= i_sample;
        end
        if (i_cmd.classify) begin
            r_is_max <= w_window && (r_middle > r_older) && (r_middle > r_cur)
                     && (r_max_cnt < opa_pkg::PeakCntW'(opa_pkg::MaxPeaks));
            r_is_min <= w_window && (r_middle < r_older) && (r_middle < r_cur)
                     && (r_min_cnt < opa_pkg::PeakCntW'(opa_pkg::MaxPeaks));
            r_idx    <= w_idx;
            r_gap    <= w_idx - r_last_idx;
            r_mag    <= w_mag;
        end
        if (i_cmd.calc) begin
            if (r_max_cnt >= opa_pkg::PeakCntW'(opa_pkg::MinPeaks)
                    && r_min_cnt >= opa_pkg::PeakCntW'(opa_pkg::MinPeaks)) begin
                r_p2p <= opa_pkg::P2pW'(r_highest) - opa_pkg::P2pW'(r_lowest);
            end else begin
                r_p2p <= '0;
            end
            r_tol_cnt <= opa_pkg::TolCntW'(r_tol)
                       * opa_pkg::TolCntW'(r_max_cnt - 1'b1);
        end
        // The product is used only for a positive peak-to-peak value, which 24 bits carry.
        if (i_cmd.mult) begin
            r_rhs <= opa_pkg::RhsW'(r_tol_cnt) * opa_pkg::RhsW'(r_p2p[SW-1:0]);
        end
    end

    opa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_gap_sum, {opa_pkg::FracW{1'b0}}}),
        .i_divisor  (r_gap_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign w_lhs    = {r_change_sum, {opa_pkg::LhsShift{1'b0}}};
    assign w_enough = (r_sample_count >= r_min_samples)
                   && (r_max_cnt >= opa_pkg::PeakCntW'(opa_pkg::MinPeaks))
                   && (r_min_cnt >= opa_pkg::PeakCntW'(opa_pkg::MinPeaks))
                   && (r_gap_cnt >= opa_pkg::GapCntW'(opa_pkg::MinGaps));

    always_comb begin
        w_osc = 1'b0;
        if (w_enough) begin
            if (r_p2p[opa_pkg::P2pW-1]) begin
                w_osc = (r_change_sum != '0) || (r_tol != '0);
            end else if (r_p2p != '0) begin
                w_osc = w_lhs < opa_pkg::LhsW'(r_rhs);
            end
        end
    end

    assign w_period = (r_gap_cnt >= opa_pkg::GapCntW'(opa_pkg::MinGaps))
                    ? w_quotient[opa_pkg::PeriodW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_osc    <= w_osc;
            r_out_p2p    <= r_p2p;
            r_out_period <= w_period;
            r_out_maxf   <= r_max_cnt;
            r_out_minf   <= r_min_cnt;
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_osc    = r_out_osc;
    assign o_p2p    = r_out_p2p;
    assign o_period = r_out_period;
    assign o_maxf   = r_out_maxf;
    assign o_minf   = r_out_minf;

    `OPA_ASSERT_IMPLY(a_max_cnt_bound, 1'b1,
        r_max_cnt <= opa_pkg::PeakCntW'(opa_pkg::MaxPeaks), "maxima count past limit")
    `OPA_ASSERT_IMPLY(a_sample_count_bound, 1'b1,
        r_sample_count <= opa_pkg::CountW'(opa_pkg::RunLength), "sample count past run length")

endmodule

// File: hdl/opa_ctrl.sv
`include "oscillation_peak_analyzer_top_assert.svh"

module opa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  opa_pkg::t_status i_status,
    output opa_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CLASSIFY = 7'b0000010,
        S_UPDATE   = 7'b0000100,
        S_CALC     = 7'b0001000,
        S_MULT     = 7'b0010000,
        S_DIV      = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                o_cmd.classify = 1'b1;
                n_state        = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc      = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the result register is free.
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `OPA_ASSERT_IMPLY(a_no_overwrite, o_cmd.out_load, w_out_free,
        "result loaded over a pending one")
    `OPA_ASSERT_IMPLY(a_div_done_waited, i_status.div_done, r_state == S_DIV,
        "divider finished outside its wait state")

endmodule
